// ===== rtl/scalc_pkg.sv =====
package scalc_pkg;

  localparam int DATA_W          = 32;
  localparam int CMD_W           = 4;
  localparam int STAT_W          = 2;
  localparam int STACK_DEPTH_DEF = 4;
  localparam int MEM_WORDS_DEF   = 16;
  localparam int DIV_STEPS       = DATA_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOP   = 4'd0,
    CMD_LOADI = 4'd1,
    CMD_LOADM = 4'd2,
    CMD_STORM = 4'd3,
    CMD_ADD   = 4'd4,
    CMD_SUB   = 4'd5,
    CMD_MUL   = 4'd6,
    CMD_DIV   = 4'd7,
    CMD_REM   = 4'd8,
    CMD_INC   = 4'd9,
    CMD_DEC   = 4'd10,
    CMD_NEG   = 4'd11,
    CMD_CLRRS = 4'd12,
    CMD_CLRMS = 4'd13
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ADDR    = 2'd1,
    ST_DIV0    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DIV
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [STAT_W-1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] mag32(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== rtl/scalc_div.sv =====
module scalc_div import scalc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              q_bit;
  logic [DATA_W-1:0] rem_nxt;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    q_bit   = ~diff[DATA_W];
    rem_nxt = q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DATA_W-2:0], q_bit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/stack_calculator_alu_core.sv =====
// an accepted command is registered and runs in S_EXEC; most commands commit there, a LOADM
// with a valid address reads memory and commits from S_LOAD, and DIV/REM with a nonzero divisor
// starts the divider and commits from S_DIV after its 32 steps; a commit waits for a free output
// one command in flight; a new one is taken while the previous result waits at the output
// synchronous active-low reset clears the stack, the memory valid bits and all control;
// memory words read as zero until written
module stack_calculator_alu_core import scalc_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int MEM_WORDS   = MEM_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(MEM_WORDS);

  state_t state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] opnd_r;

  logic [DATA_W-1:0] stk_r   [STACK_DEPTH];
  logic [DATA_W-1:0] stk_nxt [STACK_DEPTH];

  logic [DATA_W-1:0]    mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_vld_r, mem_vld_nxt;
  logic [DATA_W-1:0]    rd_data_r;
  logic                 rd_vld_r;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic qneg_r, rneg_r;

  logic              accept_in;
  logic              out_free;
  logic              addr_ok;
  logic [AW-1:0]     addr_idx;
  logic              commit;
  logic              mem_we;
  logic              mem_rd;
  logic [DATA_W-1:0] t_val, s_val;
  logic [DATA_W-1:0] mul_lo;
  logic [DATA_W-1:0] div_val;
  logic [DATA_W-1:0] load_val;
  status_t           status_v;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  scalc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign t_val    = stk_r[0];
  assign s_val    = stk_r[1];
  assign addr_ok  = ~opnd_r[DATA_W-1] && (opnd_r < DATA_W'(MEM_WORDS));
  assign addr_idx = opnd_r[AW-1:0];
  assign mul_lo   = s_val * t_val;
  assign load_val = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    if (cmd_r == CMD_REM) begin
      div_val = rneg_r ? (~div_rsp.rem + 1'b1) : div_rsp.rem;
    end else begin
      div_val = qneg_r ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    stk_nxt          = stk_r;
    mem_vld_nxt      = mem_vld_r;
    out_valid_nxt    = out_valid_r & ~out_ready;
    out_data_nxt     = out_data_r;
    mem_we           = 1'b0;
    mem_rd           = 1'b0;
    commit           = 1'b0;
    status_v         = ST_OK;
    div_req.start    = 1'b0;
    div_req.dividend = mag32(s_val);
    div_req.divisor  = mag32(t_val);

    case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == CMD_LOADM && addr_ok) begin
          mem_rd    = 1'b1;
          state_nxt = S_LOAD;
        end else if ((cmd_r == CMD_DIV || cmd_r == CMD_REM) && t_val != '0) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          commit = out_free;
        end
      end
      S_LOAD: begin
        commit = out_free;
      end
      S_DIV: begin
        commit = div_rsp.done & out_free;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (commit) begin
      case (cmd_r)
        CMD_NOP: begin
        end
        CMD_LOADI, CMD_LOADM: begin
          if (cmd_r == CMD_LOADM && !addr_ok) begin
            status_v = ST_ADDR;
          end else begin
            for (int k = STACK_DEPTH - 1; k > 0; k--) begin
              stk_nxt[k] = stk_r[k-1];
            end
            stk_nxt[0] = (cmd_r == CMD_LOADI) ? opnd_r : load_val;
          end
        end
        CMD_STORM: begin
          if (!addr_ok) begin
            status_v = ST_ADDR;
          end else begin
            mem_we                = 1'b1;
            mem_vld_nxt[addr_idx] = 1'b1;
            for (int k = 0; k < STACK_DEPTH - 1; k++) begin
              stk_nxt[k] = stk_r[k+1];
            end
            stk_nxt[STACK_DEPTH-1] = '0;
          end
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM: begin
          if ((cmd_r == CMD_DIV || cmd_r == CMD_REM) && t_val == '0) begin
            status_v = ST_DIV0;
          end else begin
            // result lands in the top, entries above the second move down
            for (int k = 1; k < STACK_DEPTH - 1; k++) begin
              stk_nxt[k] = stk_r[k+1];
            end
            stk_nxt[STACK_DEPTH-1] = '0;
            case (cmd_r)
              CMD_ADD: stk_nxt[0] = s_val + t_val;
              CMD_SUB: stk_nxt[0] = s_val - t_val;
              CMD_MUL: stk_nxt[0] = mul_lo;
              default: stk_nxt[0] = div_val;
            endcase
          end
        end
        CMD_INC: stk_nxt[0] = t_val + 1'b1;
        CMD_DEC: stk_nxt[0] = t_val - 1'b1;
        CMD_NEG: stk_nxt[0] = ~t_val + 1'b1;
        CMD_CLRRS: begin
          for (int k = 0; k < STACK_DEPTH; k++) begin
            stk_nxt[k] = '0;
          end
        end
        CMD_CLRMS: mem_vld_nxt = '0;
        default: status_v = ST_UNKNOWN;
      endcase
      out_valid_nxt          = 1'b1;
      out_data_nxt.top_value = stk_nxt[0];
      out_data_nxt.status    = status_v;
      state_nxt              = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mem_vld_r   <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) begin
        stk_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mem_vld_r   <= mem_vld_nxt;
      stk_r       <= stk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept_in) begin
      cmd_r  <= in_data.cmd;
      opnd_r <= in_data.operand;
    end
    if (div_req.start) begin
      qneg_r <= s_val[DATA_W-1] ^ t_val[DATA_W-1];
      rneg_r <= s_val[DATA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_idx] <= t_val;
    end
    if (mem_rd) begin
      rd_data_r <= mem[addr_idx];
      rd_vld_r  <= mem_vld_r[addr_idx];
    end
  end

endmodule

// ===== rtl/scalc_chk.sv =====
module scalc_chk import scalc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // one command in flight: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

  // a new result only comes from a command in flight
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared with no command in flight");

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stack_calculator_alu_core scalc_chk u_scalc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_stack_calculator_alu_core.sv =====
module tb_stack_calculator_alu_core import scalc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS      = 1850;
  localparam int CALM_ITEMS   = 250;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_CYCLES = 1_000_000;

  // codes the package leaves undefined
  localparam logic [CMD_W-1:0] CMD_UNK_A = 4'd14;
  localparam logic [CMD_W-1:0] CMD_UNK_B = 4'd15;

  localparam logic [DATA_W-1:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ALL_ONE = 32'hffff_ffff;

  class calc_scoreboard;
    logic [DATA_W-1:0] stack_words [STACK_DEPTH_DEF];
    logic [DATA_W-1:0] mem_words [MEM_WORDS_DEF];
    out_item_t expected_results [$];
    int mismatches;

    function new();
      foreach (stack_words[k]) stack_words[k] = '0;
      foreach (mem_words[k]) mem_words[k] = '0;
      mismatches = 0;
    endfunction

    function void push_word(logic [DATA_W-1:0] v);
      for (int k = STACK_DEPTH_DEF - 1; k > 0; k--) stack_words[k] = stack_words[k-1];
      stack_words[0] = v;
    endfunction

    // shift down above position start, zero fills the bottom
    function void pop_from(int start);
      for (int k = start; k < STACK_DEPTH_DEF - 1; k++) stack_words[k] = stack_words[k+1];
      stack_words[STACK_DEPTH_DEF-1] = '0;
    endfunction

    function void note_command(in_item_t item);
      logic [DATA_W-1:0] t, s, v, ma, mb, q, r;
      status_t st;
      bit addr_ok;
      out_item_t res;
      t = stack_words[0];
      s = stack_words[1];
      v = item.operand;
      st = ST_OK;
      addr_ok = !v[DATA_W-1] && (v < MEM_WORDS_DEF);
      case (item.cmd)
        CMD_NOP: ;
        CMD_LOADI: push_word(v);
        CMD_LOADM: begin
          if (addr_ok) push_word(mem_words[int'(v)]);
          else st = ST_ADDR;
        end
        CMD_STORM: begin
          if (addr_ok) begin
            mem_words[int'(v)] = t;
            pop_from(0);
          end else begin
            st = ST_ADDR;
          end
        end
        CMD_ADD: begin
          stack_words[0] = s + t;
          pop_from(1);
        end
        CMD_SUB: begin
          stack_words[0] = s - t;
          pop_from(1);
        end
        CMD_MUL: begin
          stack_words[0] = s * t;
          pop_from(1);
        end
        CMD_DIV, CMD_REM: begin
          if (t == '0) begin
            st = ST_DIV0;
          end else begin
            ma = s[DATA_W-1] ? (32'd0 - s) : s;
            mb = t[DATA_W-1] ? (32'd0 - t) : t;
            q = ma / mb;
            r = ma % mb;
            // remainder follows the dividend sign, quotient truncates
            if (item.cmd == CMD_REM) stack_words[0] = s[DATA_W-1] ? (32'd0 - r) : r;
            else stack_words[0] = (s[DATA_W-1] ^ t[DATA_W-1]) ? (32'd0 - q) : q;
            pop_from(1);
          end
        end
        CMD_INC: stack_words[0] = t + 1;
        CMD_DEC: stack_words[0] = t - 1;
        CMD_NEG: stack_words[0] = 32'd0 - t;
        CMD_CLRRS: foreach (stack_words[k]) stack_words[k] = '0;
        CMD_CLRMS: foreach (mem_words[k]) mem_words[k] = '0;
        default: st = ST_UNKNOWN;
      endcase
      res.top_value = stack_words[0];
      res.status = st;
      expected_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_results.size() == 0) begin
        $error("result with no transaction pending: top_value %0h status %0d",
               got.top_value, got.status);
        mismatches++;
      end else begin
        exp = expected_results.pop_front();
        if (got.top_value !== exp.top_value) begin
          $error("top_value: expected %0h, actual %0h", exp.top_value, got.top_value);
          mismatches++;
        end
        if (got.status !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, got.status);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  calc_scoreboard sb = new();
  int sent_count = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  stack_calculator_alu_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_command(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_cmd(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: c, operand: v};
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (sent_count == HOLD_AT) hold_request = 1'b1;
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom_range(0, 8) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = MAX_POS;
          1: v = MIN_NEG;
          2: v = ALL_ONE;
          default: v = '0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_addr();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      8: v = $urandom_range(0, 1) ? MEM_WORDS_DEF : ALL_ONE;
      9: begin
        v = $urandom;
        if (v < MEM_WORDS_DEF) v = v + MEM_WORDS_DEF;
      end
      default: v = $urandom_range(0, MEM_WORDS_DEF - 1);
    endcase
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] rand_binop();
    logic [CMD_W-1:0] c;
    case ($urandom_range(0, 4))
      0: c = CMD_ADD;
      1: c = CMD_SUB;
      2: c = CMD_MUL;
      3: c = CMD_DIV;
      default: c = CMD_REM;
    endcase
    return c;
  endfunction

  task automatic send_random_cmd();
    logic [CMD_W-1:0] c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) c = CMD_LOADI;
    else if (r < 30) c = CMD_LOADM;
    else if (r < 38) c = CMD_STORM;
    else if (r < 70) c = rand_binop();
    else if (r < 74) c = CMD_INC;
    else if (r < 78) c = CMD_DEC;
    else if (r < 82) c = CMD_NEG;
    else if (r < 85) c = CMD_CLRRS;
    else if (r < 87) c = CMD_CLRMS;
    else if (r < 92) c = CMD_NOP;
    else if (r < 96) c = $urandom_range(0, 1) ? CMD_UNK_A : CMD_UNK_B;
    else c = CMD_LOADI;
    if (c == CMD_LOADI) send_cmd(c, rand_value());
    else if (c == CMD_LOADM || c == CMD_STORM) send_cmd(c, rand_addr());
    else send_cmd(c, $urandom);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    int n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        n = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 18);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(0, 5) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 30);
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin
    logic [DATA_W-1:0] a;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wrap, min over minus one, zero divisor, bad addresses, unknown codes
    send_cmd(CMD_LOADI, MAX_POS);
    send_cmd(CMD_INC, '0);
    send_cmd(CMD_DEC, ALL_ONE);
    send_cmd(CMD_LOADI, MIN_NEG);
    send_cmd(CMD_NEG, '0);
    send_cmd(CMD_STORM, MEM_WORDS_DEF - 1);
    send_cmd(CMD_LOADM, MEM_WORDS_DEF - 1);
    send_cmd(CMD_LOADI, ALL_ONE);
    send_cmd(CMD_DIV, '0);
    send_cmd(CMD_LOADM, MEM_WORDS_DEF - 1);
    send_cmd(CMD_LOADI, ALL_ONE);
    send_cmd(CMD_REM, '0);
    send_cmd(CMD_LOADI, '0);
    send_cmd(CMD_DIV, '0);
    send_cmd(CMD_REM, '0);
    send_cmd(CMD_LOADI, 32'hffff_fff9);
    send_cmd(CMD_LOADI, 32'd2);
    send_cmd(CMD_REM, '0);
    send_cmd(CMD_MUL, '0);
    send_cmd(CMD_SUB, '0);
    send_cmd(CMD_ADD, '0);
    send_cmd(CMD_LOADM, MEM_WORDS_DEF);
    send_cmd(CMD_STORM, ALL_ONE);
    send_cmd(CMD_STORM, '0);
    send_cmd(CMD_UNK_A, '0);
    send_cmd(CMD_UNK_B, ALL_ONE);
    send_cmd(CMD_NOP, '0);
    send_cmd(CMD_CLRMS, '0);
    send_cmd(CMD_CLRRS, '0);

    while (sent_count < N_ITEMS) begin
      calm = (sent_count >= N_ITEMS - CALM_ITEMS);
      case ($urandom_range(0, 3))
        0: begin
          send_cmd(CMD_LOADI, rand_value());
          send_cmd(CMD_LOADI, rand_value());
          send_cmd(rand_binop(), $urandom);
        end
        1: begin
          a = rand_addr();
          send_cmd(CMD_LOADI, rand_value());
          send_cmd(CMD_STORM, a);
          send_cmd(CMD_LOADM, a);
        end
        default: send_random_cmd();
      endcase
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== stack_calculator_alu_core.f =====
rtl/scalc_pkg.sv
rtl/scalc_div.sv
rtl/stack_calculator_alu_core.sv
rtl/scalc_chk.sv
tb/sv/tb_stack_calculator_alu_core.sv
